// ===== design/bpia_pkg.sv =====
// Shared types and constants of the buffer pool id allocator.
`timescale 1ns / 1ps
`default_nettype none
package bpia_pkg;

  localparam int ID_W    = 10;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 3;
  localparam int SPC_W   = 7;
  localparam int LIM_W   = 5;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 7;
  localparam int DIV_CNT_W = $clog2(ID_W + 1);
  localparam int REM_W   = SPC_W + 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC_ANY = 3'd0,
    FN_ALLOC_AT  = 3'd1,
    FN_FREE      = 3'd2,
    FN_LOOKUP    = 3'd3,
    FN_NEXT      = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_RANGE    = 3'd2,
    ST_BUSY     = 3'd3,
    ST_NONE     = 3'd4
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_CHUNK = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LIMIT     = 4'd1;

endpackage
`default_nettype wire

// ===== design/bpia_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bpia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// ===== design/buffer_pool_id_allocator.sv =====
// Top level: buffer id pool allocator with per-chunk free lists in a slot RAM.
// Alloc any goes straight to dispatch; the other commands first pass through the id divider.
// A new chunk is linked one slot at a time; next in use reads slot by slot and skips absent
// chunks. One request at a time; the next is taken while a response still waits.
// Reset clears all chunk state in flip-flops; the slot RAM needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module buffer_pool_id_allocator
  import bpia_pkg::*;
#(
  parameter int NUM_CHUNKS          = 16,
  parameter int MAX_SLOTS_PER_CHUNK = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [FUNC_W-1:0]    func_i,
  input  wire logic [ID_W-1:0]      buf_id_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [STAT_W-1:0]         status_o,
  output logic [ID_W-1:0]           out_id_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int CI_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int CHUNK_W = $clog2(NUM_CHUNKS + 1);
  localparam int SLOT_W  = $clog2(MAX_SLOTS_PER_CHUNK + 1);
  localparam int SI_W    = (MAX_SLOTS_PER_CHUNK > 1) ? $clog2(MAX_SLOTS_PER_CHUNK) : 1;
  localparam int DEPTH   = NUM_CHUNKS * MAX_SLOTS_PER_CHUNK;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SLOT_W-1:0]  SLOT_NIL  = SLOT_W'(MAX_SLOTS_PER_CHUNK);
  localparam logic [CHUNK_W-1:0] CHUNK_NIL = CHUNK_W'(NUM_CHUNKS);

  typedef struct packed {
    logic              used;
    logic [SLOT_W-1:0] nxt;
    logic [SLOT_W-1:0] prv;
  } ent_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_DISP, S_CREATE, S_RD, S_CHK, S_P_RD, S_P_WR, S_N_RD, S_N_WR,
    S_S_WR, S_G_WR, S_H_RD, S_H_WR, S_G_FIN, S_SC_NX, S_SC_CK, S_MUL, S_RESP
  } state_e;

  state_e                  state_q;
  func_e                   func_q;
  logic [ID_W-1:0]         id_q;
  logic [ID_W-1:0]         cur_c_q;
  logic [SLOT_W-1:0]       cur_s_q;
  logic [SLOT_W-1:0]       sweep_q;
  logic [SLOT_W-1:0]       ent_n_q;
  logic [SLOT_W-1:0]       ent_p_q;
  logic [ID_W-1:0]         quo_q;
  logic [REM_W-1:0]        rem_q;
  logic [DIV_CNT_W-1:0]    div_cnt_q;
  status_e                 st_q;
  logic [ID_W-1:0]         res_q;
  logic                    out_valid_q;
  logic [STAT_W-1:0]       status_q;
  logic [ID_W-1:0]         out_id_q;

  logic [SPC_W-1:0]        spc_cfg_q;
  logic [LIM_W-1:0]        lim_cfg_q;

  logic                    present_q   [NUM_CHUNKS];
  logic [SLOT_W-1:0]       free_head_q [NUM_CHUNKS];
  logic [SLOT_W-1:0]       free_cnt_q  [NUM_CHUNKS];
  logic [CHUNK_W-1:0]      av_nxt_q    [NUM_CHUNKS];
  logic [CHUNK_W-1:0]      av_prv_q    [NUM_CHUNKS];
  logic [CHUNK_W-1:0]      av_head_q;
  logic [CHUNK_W-1:0]      av_tail_q;
  logic [CHUNK_W-1:0]      created_q;

  logic [SPC_W-1:0]        spc_eff;
  logic [CHUNK_W-1:0]      lim_eff;
  logic [CI_W-1:0]         c_idx;
  logic                    empty_found;
  logic [CI_W-1:0]         empty_idx;
  logic [REM_W-1:0]        rem_sh;
  logic                    ram_we;
  logic [AW-1:0]           ram_addr;
  ent_t                    ram_wdata;
  logic [1+2*SLOT_W-1:0]   ram_rdata;
  ent_t                    rd;

  function automatic logic [AW-1:0] slot_addr(input logic [ID_W-1:0] c,
                                               input logic [SLOT_W-1:0] s);
    return AW'(32'(c[CI_W-1:0]) * MAX_SLOTS_PER_CHUNK + 32'(s[SI_W-1:0]));
  endfunction

  // clamp configuration to usable ranges
  always_comb begin
    if (spc_cfg_q == '0) spc_eff = SPC_W'(1);
    else if (32'(spc_cfg_q) > MAX_SLOTS_PER_CHUNK) spc_eff = SPC_W'(MAX_SLOTS_PER_CHUNK);
    else spc_eff = spc_cfg_q;
    if (lim_cfg_q == '0) lim_eff = CHUNK_W'(1);
    else if (32'(lim_cfg_q) > NUM_CHUNKS) lim_eff = CHUNK_W'(NUM_CHUNKS);
    else lim_eff = CHUNK_W'(lim_cfg_q);
  end

  assign c_idx = cur_c_q[CI_W-1:0];
  assign rem_sh = {rem_q[REM_W-2:0], quo_q[ID_W-1]};
  assign rd = ent_t'(ram_rdata);

  // lowest empty chunk map entry below the limit
  always_comb begin
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
      if (!present_q[i] && i < 32'(lim_eff)) begin
        empty_found = 1'b1;
        empty_idx   = CI_W'(i);
      end
    end
  end

  // slot RAM port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot_addr(cur_c_q, cur_s_q);
    ram_wdata = '0;
    case (state_q)
      S_CREATE: begin
        ram_we         = 1'b1;
        ram_addr       = slot_addr(cur_c_q, sweep_q);
        ram_wdata.used = 1'b0;
        ram_wdata.nxt  = (32'(sweep_q) + 1 < 32'(spc_eff)) ? sweep_q + SLOT_W'(1) : SLOT_NIL;
        ram_wdata.prv  = (sweep_q == '0) ? SLOT_NIL : sweep_q - SLOT_W'(1);
      end
      S_P_RD: ram_addr = slot_addr(cur_c_q, ent_p_q);
      S_P_WR: begin
        ram_we    = 1'b1;
        ram_addr  = slot_addr(cur_c_q, ent_p_q);
        ram_wdata = '{used: rd.used, nxt: ent_n_q, prv: rd.prv};
      end
      S_N_RD: ram_addr = slot_addr(cur_c_q, ent_n_q);
      S_N_WR: begin
        ram_we    = 1'b1;
        ram_addr  = slot_addr(cur_c_q, ent_n_q);
        ram_wdata = '{used: rd.used, nxt: rd.nxt, prv: ent_p_q};
      end
      S_S_WR: begin
        ram_we    = 1'b1;
        ram_wdata = '{used: 1'b1, nxt: ent_n_q, prv: ent_p_q};
      end
      S_G_WR: begin
        ram_we    = 1'b1;
        ram_wdata = '{used: 1'b0, nxt: free_head_q[c_idx], prv: SLOT_NIL};
      end
      S_H_RD: ram_addr = slot_addr(cur_c_q, free_head_q[c_idx]);
      S_H_WR: begin
        ram_we    = 1'b1;
        ram_addr  = slot_addr(cur_c_q, free_head_q[c_idx]);
        ram_wdata = '{used: rd.used, nxt: rd.nxt, prv: cur_s_q};
      end
      default: ;
    endcase
  end

  bpia_ram #(
    .WIDTH (1 + 2 * SLOT_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // sequencer, chunk state and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= FN_ALLOC_ANY;
      id_q        <= '0;
      cur_c_q     <= '0;
      cur_s_q     <= '0;
      sweep_q     <= '0;
      ent_n_q     <= '0;
      ent_p_q     <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      div_cnt_q   <= '0;
      st_q        <= ST_NONE;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      out_id_q    <= '0;
      spc_cfg_q   <= SPC_W'(64);
      lim_cfg_q   <= LIM_W'(16);
      av_head_q   <= CHUNK_NIL;
      av_tail_q   <= CHUNK_NIL;
      created_q   <= '0;
      for (int i = 0; i < NUM_CHUNKS; i++) begin
        present_q[i]   <= 1'b0;
        free_cnt_q[i]  <= '0;
        free_head_q[i] <= SLOT_NIL;
        av_nxt_q[i]    <= CHUNK_NIL;
        av_prv_q[i]    <= CHUNK_NIL;
      end
    end else begin
      // S_RESP reloads the response register itself
      if (out_valid_q && out_ready_i && state_q != S_RESP) out_valid_q <= 1'b0;

      // configuration, only taken while idle; a new chunk size empties the pool
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_SLOTS_PER_CHUNK) begin
          spc_cfg_q <= cfg_data_i;
          av_head_q <= CHUNK_NIL;
          av_tail_q <= CHUNK_NIL;
          created_q <= '0;
          for (int i = 0; i < NUM_CHUNKS; i++) begin
            present_q[i]  <= 1'b0;
            free_cnt_q[i] <= '0;
          end
        end else if (cfg_index_i == CFG_CHUNK_LIMIT) begin
          lim_cfg_q <= cfg_data_i[LIM_W-1:0];
        end
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q    <= func_e'(func_i);
            id_q      <= buf_id_i;
            quo_q     <= buf_id_i;
            rem_q     <= '0;
            div_cnt_q <= '0;
            case (func_e'(func_i))
              FN_ALLOC_ANY: state_q <= S_DISP;
              FN_ALLOC_AT, FN_FREE, FN_LOOKUP, FN_NEXT: state_q <= S_DIV;
              default: begin
                st_q    <= ST_NONE;
                state_q <= S_RESP;
              end
            endcase
          end
        end

        // restoring divider, one quotient bit per cycle
        S_DIV: begin
          if (rem_sh >= REM_W'(spc_eff)) begin
            rem_q <= rem_sh - REM_W'(spc_eff);
            quo_q <= {quo_q[ID_W-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[ID_W-2:0], 1'b0};
          end
          div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
          if (div_cnt_q == DIV_CNT_W'(ID_W - 1)) state_q <= S_DISP;
        end

        S_DISP: begin
          case (func_q)
            FN_ALLOC_ANY: begin
              if (av_head_q != CHUNK_NIL) begin
                cur_c_q <= ID_W'(av_head_q);
                cur_s_q <= free_head_q[av_head_q[CI_W-1:0]];
                state_q <= S_RD;
              end else if (created_q >= lim_eff || !empty_found) begin
                st_q    <= ST_NO_SPACE;
                state_q <= S_RESP;
              end else begin
                cur_c_q <= ID_W'(empty_idx);
                sweep_q <= '0;
                state_q <= S_CREATE;
              end
            end
            FN_ALLOC_AT: begin
              cur_c_q <= quo_q;
              cur_s_q <= SLOT_W'(rem_q);
              sweep_q <= '0;
              if (32'(quo_q) >= 32'(lim_eff)) begin
                st_q    <= ST_RANGE;
                state_q <= S_RESP;
              end else if (present_q[quo_q[CI_W-1:0]]) begin
                state_q <= S_RD;
              end else if (created_q >= lim_eff) begin
                st_q    <= ST_NO_SPACE;
                state_q <= S_RESP;
              end else begin
                state_q <= S_CREATE;
              end
            end
            FN_FREE, FN_LOOKUP: begin
              cur_c_q <= quo_q;
              cur_s_q <= SLOT_W'(rem_q);
              if ((func_q == FN_FREE && 32'(quo_q) >= NUM_CHUNKS) ||
                  (func_q == FN_LOOKUP && 32'(quo_q) >= 32'(lim_eff))) begin
                st_q    <= ST_RANGE;
                state_q <= S_RESP;
              end else if (!present_q[quo_q[CI_W-1:0]]) begin
                st_q    <= ST_NONE;
                state_q <= S_RESP;
              end else begin
                state_q <= S_RD;
              end
            end
            default: begin
              cur_c_q <= quo_q;
              cur_s_q <= SLOT_W'(rem_q);
              state_q <= S_SC_NX;
            end
          endcase
        end

        // link all slots of a new chunk, then add it to the available list
        S_CREATE: begin
          sweep_q <= sweep_q + SLOT_W'(1);
          if (32'(sweep_q) + 1 >= 32'(spc_eff)) begin
            present_q[c_idx]   <= 1'b1;
            created_q          <= created_q + CHUNK_W'(1);
            free_cnt_q[c_idx]  <= SLOT_W'(spc_eff);
            free_head_q[c_idx] <= '0;
            av_nxt_q[c_idx]    <= CHUNK_NIL;
            av_prv_q[c_idx]    <= av_tail_q;
            if (av_tail_q != CHUNK_NIL) av_nxt_q[av_tail_q[CI_W-1:0]] <= CHUNK_W'(c_idx);
            else av_head_q <= CHUNK_W'(c_idx);
            av_tail_q <= CHUNK_W'(c_idx);
            if (func_q == FN_ALLOC_ANY) cur_s_q <= '0;
            state_q <= S_RD;
          end
        end

        S_RD: state_q <= S_CHK;

        S_CHK: begin
          ent_n_q <= rd.nxt;
          ent_p_q <= rd.prv;
          case (func_q)
            FN_LOOKUP: begin
              st_q    <= rd.used ? ST_OK : ST_NONE;
              res_q   <= id_q;
              state_q <= S_RESP;
            end
            FN_FREE: begin
              if (!rd.used) begin
                st_q    <= ST_NONE;
                state_q <= S_RESP;
              end else begin
                state_q <= S_G_WR;
              end
            end
            default: begin
              if (func_q == FN_ALLOC_AT && rd.used) begin
                st_q    <= ST_BUSY;
                state_q <= S_RESP;
              end else if (rd.prv != SLOT_NIL) begin
                state_q <= S_P_RD;
              end else begin
                free_head_q[c_idx] <= rd.nxt;
                state_q <= (rd.nxt != SLOT_NIL) ? S_N_RD : S_S_WR;
              end
            end
          endcase
        end

        S_P_RD: state_q <= S_P_WR;
        S_P_WR: state_q <= (ent_n_q != SLOT_NIL) ? S_N_RD : S_S_WR;
        S_N_RD: state_q <= S_N_WR;
        S_N_WR: state_q <= S_S_WR;

        // slot taken: count down, drop chunk from available list when full
        S_S_WR: begin
          free_cnt_q[c_idx] <= free_cnt_q[c_idx] - SLOT_W'(1);
          if (free_cnt_q[c_idx] == SLOT_W'(1)) begin
            if (av_prv_q[c_idx] != CHUNK_NIL)
              av_nxt_q[av_prv_q[c_idx][CI_W-1:0]] <= av_nxt_q[c_idx];
            else av_head_q <= av_nxt_q[c_idx];
            if (av_nxt_q[c_idx] != CHUNK_NIL)
              av_prv_q[av_nxt_q[c_idx][CI_W-1:0]] <= av_prv_q[c_idx];
            else av_tail_q <= av_prv_q[c_idx];
            av_nxt_q[c_idx] <= CHUNK_NIL;
            av_prv_q[c_idx] <= CHUNK_NIL;
          end
          st_q  <= ST_OK;
          res_q <= id_q;
          state_q <= (func_q == FN_ALLOC_ANY) ? S_MUL : S_RESP;
        end

        S_G_WR: state_q <= (free_head_q[c_idx] != SLOT_NIL) ? S_H_RD : S_G_FIN;
        S_H_RD: state_q <= S_H_WR;
        S_H_WR: state_q <= S_G_FIN;

        // freed slot becomes head; chunk rejoins available list at the tail
        S_G_FIN: begin
          free_head_q[c_idx] <= cur_s_q;
          free_cnt_q[c_idx]  <= free_cnt_q[c_idx] + SLOT_W'(1);
          if (free_cnt_q[c_idx] == '0) begin
            av_nxt_q[c_idx] <= CHUNK_NIL;
            av_prv_q[c_idx] <= av_tail_q;
            if (av_tail_q != CHUNK_NIL) av_nxt_q[av_tail_q[CI_W-1:0]] <= CHUNK_W'(c_idx);
            else av_head_q <= CHUNK_W'(c_idx);
            av_tail_q <= CHUNK_W'(c_idx);
          end
          st_q    <= ST_OK;
          res_q   <= id_q;
          state_q <= S_RESP;
        end

        // next in use: one slot read per visit
        S_SC_NX: begin
          if (32'(cur_c_q) >= 32'(lim_eff)) begin
            st_q    <= ST_NONE;
            state_q <= S_RESP;
          end else if (!present_q[c_idx] || 32'(cur_s_q) >= 32'(spc_eff)) begin
            cur_c_q <= cur_c_q + ID_W'(1);
            cur_s_q <= '0;
          end else begin
            state_q <= S_SC_CK;
          end
        end

        S_SC_CK: begin
          if (rd.used) begin
            st_q    <= ST_OK;
            state_q <= S_MUL;
          end else begin
            cur_s_q <= cur_s_q + SLOT_W'(1);
            state_q <= S_SC_NX;
          end
        end

        S_MUL: begin
          res_q   <= ID_W'(32'(cur_c_q) * 32'(spc_eff) + 32'(cur_s_q));
          state_q <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            status_q    <= st_q;
            out_id_q    <= (st_q == ST_OK) ? res_q : '0;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_id_o    = out_id_q;

  // checks
  a_id_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> out_id_o == '0)
    else $error("nonzero id with error status");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_create_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CREATE |-> !present_q[c_idx])
    else $error("creating a chunk that is present");

  a_avail_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (av_head_q == CHUNK_NIL) == (av_tail_q == CHUNK_NIL))
    else $error("available list head and tail disagree");

  a_created_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(created_q) <= NUM_CHUNKS)
    else $error("chunk count overflow");

endmodule
`default_nettype wire

// ===== dv/buffer_pool_id_allocator_checker.sv =====
// Checker for the buffer pool id allocator: watches the channels, predicts responses, compares.
`timescale 1ns / 1ps
module bpia_pool_checker
  import bpia_pkg::*;
#(
  parameter int NUM_CHUNKS          = 16,
  parameter int MAX_SLOTS_PER_CHUNK = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [ID_W-1:0]      buf_id_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [STAT_W-1:0]    status_i,
  input  logic [ID_W-1:0]      out_id_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int SLOT_NIL  = MAX_SLOTS_PER_CHUNK;
  localparam int CHUNK_NIL = NUM_CHUNKS;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
  } resp_t;

  resp_t resp_q[$];

  // shadow configuration
  logic [SPC_W-1:0] spc_reg;
  logic [LIM_W-1:0] lim_reg;

  // shadow pool
  bit present   [NUM_CHUNKS];
  int created;
  bit in_use    [NUM_CHUNKS][MAX_SLOTS_PER_CHUNK];
  int slot_nxt  [NUM_CHUNKS][MAX_SLOTS_PER_CHUNK];
  int slot_prv  [NUM_CHUNKS][MAX_SLOTS_PER_CHUNK];
  int free_head [NUM_CHUNKS];
  int free_cnt  [NUM_CHUNKS];
  int av_nxt    [NUM_CHUNKS];
  int av_prv    [NUM_CHUNKS];
  int av_head, av_tail;

  function automatic int slots_eff();
    int v;
    v = spc_reg;
    if (v < 1) v = 1;
    if (v > MAX_SLOTS_PER_CHUNK) v = MAX_SLOTS_PER_CHUNK;
    return v;
  endfunction

  function automatic int limit_eff();
    int v;
    v = lim_reg;
    if (v < 1) v = 1;
    if (v > NUM_CHUNKS) v = NUM_CHUNKS;
    return v;
  endfunction

  task automatic pool_wipe();
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      present[c]   = 0;
      free_cnt[c]  = 0;
      free_head[c] = SLOT_NIL;
      av_nxt[c]    = CHUNK_NIL;
      av_prv[c]    = CHUNK_NIL;
      for (int s = 0; s < MAX_SLOTS_PER_CHUNK; s++) begin
        in_use[c][s]   = 0;
        slot_nxt[c][s] = 0;
        slot_prv[c][s] = 0;
      end
    end
    created = 0;
    av_head = CHUNK_NIL;
    av_tail = CHUNK_NIL;
  endtask

  task automatic avail_push(int c);
    av_nxt[c] = CHUNK_NIL;
    av_prv[c] = av_tail;
    if (av_tail < NUM_CHUNKS) av_nxt[av_tail] = c;
    else av_head = c;
    av_tail = c;
  endtask

  task automatic avail_unlink(int c);
    int n, p;
    n = av_nxt[c];
    p = av_prv[c];
    if (p < NUM_CHUNKS) av_nxt[p] = n;
    else av_head = n;
    if (n < NUM_CHUNKS) av_prv[n] = p;
    else av_tail = p;
    av_nxt[c] = CHUNK_NIL;
    av_prv[c] = CHUNK_NIL;
  endtask

  task automatic chunk_build(int c, int spc);
    present[c]   = 1;
    created++;
    free_cnt[c]  = spc;
    free_head[c] = 0;
    for (int s = 0; s < spc; s++) begin
      in_use[c][s]   = 0;
      slot_prv[c][s] = (s == 0) ? SLOT_NIL : s - 1;
      slot_nxt[c][s] = (s + 1 < spc) ? s + 1 : SLOT_NIL;
    end
    avail_push(c);
  endtask

  task automatic slot_take(int c, int s);
    int n, p;
    n = slot_nxt[c][s];
    p = slot_prv[c][s];
    if (p < MAX_SLOTS_PER_CHUNK) slot_nxt[c][p] = n;
    else free_head[c] = n;
    if (n < MAX_SLOTS_PER_CHUNK) slot_prv[c][n] = p;
    free_cnt[c]--;
    if (free_cnt[c] == 0) avail_unlink(c);
    in_use[c][s] = 1;
  endtask

  task automatic slot_give(int c, int s);
    int h;
    h = free_head[c];
    in_use[c][s]   = 0;
    slot_prv[c][s] = SLOT_NIL;
    slot_nxt[c][s] = h;
    if (h < MAX_SLOTS_PER_CHUNK) slot_prv[c][h] = s;
    free_head[c] = s;
    if (free_cnt[c] == 0) avail_push(c);
    free_cnt[c]++;
  endtask

  // Work out the response to one request and update the shadow pool.
  task automatic pool_predict(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                              output resp_t rsp);
    int spc, lim, c, s, k, res;
    status_e st;
    bit hit;
    spc = slots_eff();
    lim = limit_eff();
    c   = id / spc;
    s   = id % spc;
    st  = ST_NONE;
    res = 0;
    case (fn)
      FN_ALLOC_ANY: begin
        hit = 1;
        if (av_head >= NUM_CHUNKS) begin
          if (created >= lim) hit = 0;
          else begin
            k = 0;
            while (k < lim && present[k]) k++;
            if (k >= lim) hit = 0;
            else chunk_build(k, spc);
          end
        end
        if (!hit) st = ST_NO_SPACE;
        else begin
          c = av_head;
          s = free_head[c];
          slot_take(c, s);
          st  = ST_OK;
          res = c * spc + s;
        end
      end
      FN_ALLOC_AT: begin
        if (c >= lim) st = ST_RANGE;
        else if (!present[c] && created >= lim) st = ST_NO_SPACE;
        else begin
          if (!present[c]) chunk_build(c, spc);
          if (in_use[c][s]) st = ST_BUSY;
          else begin
            slot_take(c, s);
            st  = ST_OK;
            res = id;
          end
        end
      end
      FN_FREE: begin
        if (c >= NUM_CHUNKS) st = ST_RANGE;
        else if (present[c] && in_use[c][s]) begin
          slot_give(c, s);
          st  = ST_OK;
          res = id;
        end
      end
      FN_LOOKUP: begin
        if (c >= lim) st = ST_RANGE;
        else if (present[c] && in_use[c][s]) begin
          st  = ST_OK;
          res = id;
        end
      end
      FN_NEXT: begin
        // later chunks are scanned from slot zero; absent ones are skipped
        while (c < lim && st != ST_OK) begin
          if (present[c]) begin
            while (s < spc && st != ST_OK) begin
              if (in_use[c][s]) begin
                st  = ST_OK;
                res = c * spc + s;
              end
              s++;
            end
          end
          c++;
          s = 0;
        end
      end
      default: st = ST_NONE;
    endcase
    rsp.status = st;
    rsp.id     = (st == ST_OK) ? res[ID_W-1:0] : '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    resp_t want, got, rsp;
    if (!rst_ni) begin
      spc_reg = 7'd64;
      lim_reg = 5'd16;
      pool_wipe();
      resp_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // response side first: it always belongs to an earlier request
      if (out_valid_i && out_ready_i) begin
        got.status = status_i;
        got.id     = out_id_i;
        if (resp_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: response with none pending: status %0d id %0d",
                     $realtime, got.status, got.id);
        end else begin
          want = resp_q.pop_front();
          if (want.status !== got.status || want.id !== got.id) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch: expected status %0d id %0d, got status %0d id %0d",
                       $realtime, want.status, want.id, got.status, got.id);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_SLOTS_PER_CHUNK) begin
          spc_reg = cfg_data_i[SPC_W-1:0];
          pool_wipe();
        end else if (cfg_index_i == CFG_CHUNK_LIMIT) begin
          lim_reg = cfg_data_i[LIM_W-1:0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        pool_predict(func_i, buf_id_i, rsp);
        resp_q.push_back(rsp);
      end
      pending_o = resp_q.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the buffer pool id allocator testbench: stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps
module testbench;
  import bpia_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [FUNC_W-1:0]    func_i = '0;
  logic [ID_W-1:0]      buf_id_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [STAT_W-1:0]    status_o;
  logic [ID_W-1:0]      out_id_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  int                   fail_count;
  int                   pending;

  // stimulus shaping shared with the receiver
  bit no_idle = 0;
  bit hold_rx = 0;
  int spc_now = 64;
  int lim_now = 16;
  int idle_cnt = 0;

  always #5 clk_i = ~clk_i;

  buffer_pool_id_allocator DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .buf_id_i,
    .out_valid_o, .out_ready_i, .status_o, .out_id_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  bpia_pool_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .func_i, .buf_id_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o), .out_id_i(out_id_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= 60000) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // response side: random stalls, one long hold-off on request
  initial begin
    int k;
    @(posedge rst_ni);
    forever begin
      k = no_idle ? 0 : $urandom_range(0, 6);
      if (hold_rx) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_rx = 0;
      end else if (k > 0) begin
        out_ready_i <= 1'b0;
        repeat (k) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_req(func_e fn, logic [ID_W-1:0] id);
    send_raw(fn, id);
  endtask

  task automatic send_raw(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    buf_id_i   <= id;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // register writes only with the block idle
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    int v;
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_SLOTS_PER_CHUNK) begin
      v = int'(val);
      spc_now = (v < 1) ? 1 : (v > 64) ? 64 : v;
    end else if (idx == CFG_CHUNK_LIMIT) begin
      v = int'(val[LIM_W-1:0]);
      lim_now = (v < 1) ? 1 : (v > 16) ? 16 : v;
    end
  endtask

  // mostly well-formed pool traffic over the live id span, some noise
  task automatic random_burst(int n);
    int r, span;
    logic [ID_W-1:0] id;
    for (int i = 0; i < n; i++) begin
      span = spc_now * lim_now;
      if (span > 1024) span = 1024;
      r  = $urandom_range(0, 99);
      id = ID_W'($urandom_range(0, span - 1));
      if (i % 40 == 0) no_idle = ~no_idle;
      if (r < 30)      send_req(FN_ALLOC_ANY, ID_W'($urandom));
      else if (r < 45) send_req(FN_ALLOC_AT, id);
      else if (r < 72) send_req(FN_FREE, id);
      else if (r < 82) send_req(FN_LOOKUP, id);
      else if (r < 92) send_req(FN_NEXT, id);
      else             send_raw(FUNC_W'($urandom_range(0, 7)), ID_W'($urandom));
    end
    no_idle = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default pool of 16 chunks by 64 slots
    send_req(FN_LOOKUP, 10'd0);
    send_req(FN_NEXT, 10'd0);
    send_req(FN_FREE, 10'd500);
    send_req(FN_ALLOC_ANY, 10'd0);
    send_req(FN_ALLOC_AT, 10'd1023);
    send_req(FN_ALLOC_AT, 10'd1023);
    send_req(FN_LOOKUP, 10'd1023);
    send_req(FN_NEXT, 10'd1);
    send_req(FN_FREE, 10'd1023);
    send_req(FN_FREE, 10'd1023);
    send_req(FN_NEXT, 10'd1023);
    send_raw(3'd5, 10'h2AA);
    send_raw(3'd6, 10'h155);
    send_raw(3'd7, 10'd0);

    // directed: one chunk of one slot
    cfg_write(CFG_SLOTS_PER_CHUNK, 7'd0);
    cfg_write(CFG_CHUNK_LIMIT, 7'd0);
    send_req(FN_ALLOC_ANY, 10'd0);
    send_req(FN_ALLOC_ANY, 10'd0);
    send_req(FN_ALLOC_AT, 10'd5);
    send_req(FN_LOOKUP, 10'd5);
    send_req(FN_FREE, 10'd20);
    send_req(FN_FREE, 10'd3);
    send_req(FN_ALLOC_AT, 10'd0);
    send_req(FN_FREE, 10'd0);
    send_req(FN_ALLOC_AT, 10'd0);
    cfg_write(4'd9, 7'h7F);

    // random phases across settings
    cfg_write(CFG_SLOTS_PER_CHUNK, 7'd4);
    cfg_write(CFG_CHUNK_LIMIT, 7'd3);
    random_burst(110);
    hold_rx = 1;
    no_idle = 1;
    for (int i = 0; i < 20; i++) send_req(FN_ALLOC_ANY, 10'd0);
    no_idle = 0;
    drain();
    random_burst(100);

    cfg_write(CFG_SLOTS_PER_CHUNK, 7'd127);
    cfg_write(CFG_CHUNK_LIMIT, 7'd31);
    random_burst(90);

    cfg_write(CFG_SLOTS_PER_CHUNK, 7'd3);
    cfg_write(CFG_CHUNK_LIMIT, 7'd16);
    random_burst(120);
    // shrink the limit with chunks above it still in the pool
    cfg_write(CFG_CHUNK_LIMIT, 7'd2);
    random_burst(90);

    cfg_write(CFG_SLOTS_PER_CHUNK, 7'd1);
    cfg_write(CFG_CHUNK_LIMIT, 7'd16);
    random_burst(90);

    cfg_write(CFG_SLOTS_PER_CHUNK, 7'd17);
    cfg_write(CFG_CHUNK_LIMIT, 7'd4);
    random_burst(110);

    cfg_write(CFG_SLOTS_PER_CHUNK, 7'd64);
    cfg_write(CFG_CHUNK_LIMIT, 7'd2);
    random_burst(90);
    cfg_write(CFG_CHUNK_LIMIT, 7'd1);
    random_burst(110);

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
